// ----- design/rcap_pkg.sv -----
// Package for the RESP array request parser.
// Holds phase, event and error codes, the result record and shared constants.
// No dependencies.
package rcap_pkg;

    // Default payload length width handed to the top level.
    localparam int LENGTH_BITS_DEF = 32;

    // Element count width limit; the count cap follows from it.
    localparam int COUNT_BITS = 16;
    localparam logic [15:0] COUNT_CAP =
        (COUNT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COUNT_BITS) - 32'd1);

    // Reset values of the configuration registers.
    localparam logic [15:0] MAX_ELEMENTS_RST    = 16'd1024;
    localparam logic [31:0] MAX_BULK_LENGTH_RST = 32'd536870912;

    // Protocol characters.
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [0:0] {
        REG_MAX_ELEMENTS    = 1'b0,
        REG_MAX_BULK_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_COUNT    = 4'd1,
        PH_COUNT_LF = 4'd2,
        PH_DOLLAR   = 4'd3,
        PH_LEN      = 4'd4,
        PH_NULL_ONE = 4'd5,
        PH_NULL_CR  = 4'd6,
        PH_NULL_LF  = 4'd7,
        PH_LEN_LF   = 4'd8,
        PH_DATA     = 4'd9,
        PH_DATA_CR  = 4'd10,
        PH_DATA_LF  = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        EV_BYTE = 2'd0,
        EV_ELEM = 2'd1,
        EV_ERR  = 2'd2
    } ev_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_BYTE  = 3'd1,
        ERR_EMPTY = 3'd2,
        ERR_COUNT = 3'd3,
        ERR_LEN   = 3'd4
    } err_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [7:0]  data;
        logic [15:0] index;
        logic [31:0] length;
        logic        is_null;
        logic        last;
        err_t        code;
    } res_t;

endpackage

// ----- design/rcap_in_reg.sv -----
// Input register of the RESP array request parser.
// Holds one accepted byte until the parse stage takes it; uses rcap_pkg.
module rcap_in_reg
    import rcap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic       drain_ok,
    output logic       step,
    output logic [7:0] byte_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The held byte moves on whenever the result side can take its outcome.
    assign step     = valid_reg && drain_ok;
    assign in_ready = !valid_reg || drain_ok;
    assign byte_q   = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_in;
        end
    end

endmodule

// ----- design/rcap_parse_core.sv -----
// Parse stage of the RESP array request parser: phase machine, number
// accumulator and element counters. Uses rcap_pkg.
module rcap_parse_core
    import rcap_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  byte_q,
    input  logic [15:0] max_elements,
    input  logic [31:0] max_bulk_length,
    output logic        res_valid,
    output res_t        res
);

    // Lengths never exceed 32 bits, so the accumulator stops there.
    localparam int ACC_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
    localparam int CMP_W = ACC_W + 4;
    localparam logic [31:0] LEN_CAP =
        (ACC_W >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ACC_W) - 64'd1);

    phase_t             phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               seen_reg, seen_next;
    logic [15:0]        left_reg, left_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic [ACC_W-1:0]   pay_left_reg, pay_left_next;
    logic [ACC_W-1:0]   pay_len_reg, pay_len_next;

    logic               is_digit;
    logic [CMP_W-1:0]   acc_ext;
    logic [CMP_W-1:0]   acc_new;
    logic [15:0]        cnt_lim;
    logic [31:0]        len_lim;
    logic               cnt_over;
    logic               len_over;
    logic [ACC_W-1:0]   pay_dec;
    logic [15:0]        left_dec;

    err_t               fail_code;
    logic               fin;
    logic               fin_null;

    assign is_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
    assign acc_ext  = CMP_W'(acc_reg);
    // acc * 10 + digit as two shifted adds; the low nibble of an ASCII digit is its value.
    assign acc_new  = (acc_ext << 3) + (acc_ext << 1) + CMP_W'(byte_q[3:0]);
    assign cnt_lim  = (max_elements < COUNT_CAP) ? max_elements : COUNT_CAP;
    assign len_lim  = (max_bulk_length < LEN_CAP) ? max_bulk_length : LEN_CAP;
    assign cnt_over = acc_new > CMP_W'(cnt_lim);
    assign len_over = acc_new > CMP_W'(ACC_W'(len_lim));
    assign pay_dec  = (pay_left_reg != '0) ? pay_left_reg - ACC_W'(1) : pay_left_reg;
    assign left_dec = left_reg - 16'd1;

    // Byte decode: error code, element completion.
    always_comb
    begin
        fail_code = ERR_NONE;
        fin       = 1'b0;
        fin_null  = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (byte_q != CH_STAR) fail_code = ERR_BYTE;
            end
            PH_COUNT:
            begin
                if (is_digit)
                begin
                    if (cnt_over) fail_code = ERR_COUNT;
                end
                else if (!(byte_q == CH_CR && seen_reg))
                begin
                    fail_code = ERR_BYTE;
                end
            end
            PH_COUNT_LF:
            begin
                if (byte_q != CH_LF) fail_code = ERR_BYTE;
                else if (acc_reg == '0) fail_code = ERR_EMPTY;
            end
            PH_DOLLAR:
            begin
                if (byte_q != CH_DOLLAR) fail_code = ERR_BYTE;
            end
            PH_LEN:
            begin
                if (is_digit)
                begin
                    if (len_over) fail_code = ERR_LEN;
                end
                else if (!(byte_q == CH_MINUS && !seen_reg) &&
                         !(byte_q == CH_CR && seen_reg))
                begin
                    fail_code = ERR_BYTE;
                end
            end
            PH_NULL_ONE:
            begin
                if (byte_q != CH_ONE) fail_code = ERR_BYTE;
            end
            PH_NULL_CR:
            begin
                if (byte_q != CH_CR) fail_code = ERR_BYTE;
            end
            PH_NULL_LF:
            begin
                if (byte_q != CH_LF) fail_code = ERR_BYTE;
                else
                begin
                    fin      = 1'b1;
                    fin_null = 1'b1;
                end
            end
            PH_LEN_LF:
            begin
                if (byte_q != CH_LF) fail_code = ERR_BYTE;
            end
            PH_DATA:
            begin
                fail_code = ERR_NONE;
            end
            PH_DATA_CR:
            begin
                if (byte_q != CH_CR) fail_code = ERR_BYTE;
            end
            PH_DATA_LF:
            begin
                if (byte_q != CH_LF) fail_code = ERR_BYTE;
                else fin = 1'b1;
            end
            default:
            begin
                fail_code = ERR_BYTE;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        left_next     = left_reg;
        cnt_next      = cnt_reg;
        pay_left_next = pay_left_reg;
        pay_len_next  = pay_len_reg;
        if (fail_code != ERR_NONE || (fin && left_dec == 16'd0))
        begin
            // Any error, or the final element, clears the command.
            phase_next    = PH_IDLE;
            acc_next      = '0;
            seen_next     = 1'b0;
            left_next     = '0;
            cnt_next      = '0;
            pay_left_next = '0;
            pay_len_next  = '0;
        end
        else if (fin)
        begin
            phase_next    = PH_DOLLAR;
            cnt_next      = cnt_reg + 16'd1;
            left_next     = left_dec;
            pay_left_next = '0;
            pay_len_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE, PH_DOLLAR:
                begin
                    phase_next = (phase_reg == PH_IDLE) ? PH_COUNT : PH_LEN;
                    acc_next   = '0;
                    seen_next  = 1'b0;
                end
                PH_COUNT, PH_LEN:
                begin
                    if (is_digit)
                    begin
                        acc_next  = ACC_W'(acc_new);
                        seen_next = 1'b1;
                    end
                    else if (byte_q == CH_CR)
                    begin
                        phase_next = (phase_reg == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
                    end
                    else
                    begin
                        phase_next = PH_NULL_ONE;
                    end
                end
                PH_COUNT_LF:
                begin
                    left_next  = acc_reg[15:0];
                    cnt_next   = '0;
                    phase_next = PH_DOLLAR;
                end
                PH_NULL_ONE:
                begin
                    phase_next = PH_NULL_CR;
                end
                PH_NULL_CR:
                begin
                    phase_next = PH_NULL_LF;
                end
                PH_LEN_LF:
                begin
                    pay_len_next  = acc_reg;
                    pay_left_next = acc_reg;
                    phase_next    = (acc_reg == '0) ? PH_DATA_CR : PH_DATA;
                end
                PH_DATA:
                begin
                    pay_left_next = pay_dec;
                    if (pay_dec == '0) phase_next = PH_DATA_CR;
                end
                PH_DATA_CR:
                begin
                    phase_next = PH_DATA_LF;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result of this byte.
    always_comb
    begin
        res         = '0;
        res.kind    = EV_BYTE;
        res.code    = ERR_NONE;
        res_valid   = 1'b0;
        if (fail_code != ERR_NONE)
        begin
            res_valid = 1'b1;
            res.kind  = EV_ERR;
            res.code  = fail_code;
        end
        else if (fin)
        begin
            res_valid   = 1'b1;
            res.kind    = EV_ELEM;
            res.index   = cnt_reg;
            res.length  = fin_null ? 32'd0 : 32'(pay_len_reg);
            res.is_null = fin_null;
            res.last    = (left_reg == 16'd1);
        end
        else if (phase_reg == PH_DATA)
        begin
            res_valid  = 1'b1;
            res.kind   = EV_BYTE;
            res.data   = byte_q;
            res.index  = cnt_reg;
            res.length = 32'(pay_len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            acc_reg      <= '0;
            seen_reg     <= 1'b0;
            left_reg     <= '0;
            cnt_reg      <= '0;
            pay_left_reg <= '0;
            pay_len_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            seen_reg     <= seen_next;
            left_reg     <= left_next;
            cnt_reg      <= cnt_next;
            pay_left_reg <= pay_left_next;
            pay_len_reg  <= pay_len_next;
        end
    end

endmodule

// ----- design/rcap_out_reg.sv -----
// Result register of the RESP array request parser.
// Holds one result until the consumer takes it; uses rcap_pkg.
module rcap_out_reg
    import rcap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic res_valid,
    input  res_t res,
    output logic drain_ok,
    output logic out_valid,
    input  logic out_ready,
    output res_t res_q
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign drain_ok  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_q     = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (drain_ok)
        begin
            valid_next = step && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain_ok && step && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- design/resp_command_array_parser.sv -----
// Items pass the input register, then the parse stage, then the result register.
// Throughput: one item per cycle, limited only by out_ready; the input register and the
// result register each hold one item, and the parse stage decodes bytes combinationally.
// Reset (rst_n low, asynchronous) empties both registers, returns the parser to waiting
// for '*' with all counters cleared, and sets max_elements to 1024 and
// max_bulk_length to 2^29.
module resp_command_array_parser
    import rcap_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Request byte stream.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    // Parse events.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [7:0]  data_byte,
    output logic [15:0] element_index,
    output logic [31:0] element_length,
    output logic        is_null,
    output logic        last_of_command,
    output logic [2:0]  error_code,
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] max_elements_reg;
    logic [31:0] max_bulk_length_reg;

    logic        step;
    logic        drain_ok;
    logic [7:0]  byte_q;
    logic        res_valid;
    res_t        res;
    res_t        res_q;

    // The two limit registers. Writes are expected only while the parser is idle,
    // and take effect on the next digit checked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_elements_reg    <= MAX_ELEMENTS_RST;
            max_bulk_length_reg <= MAX_BULK_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_ELEMENTS)
            begin
                max_elements_reg <= cfg_data[15:0];
            end
            else
            begin
                max_bulk_length_reg <= cfg_data;
            end
        end
    end

    // The input register takes a new item whenever its held item can move on,
    // so a full result register with a waiting consumer is the only stall.
    rcap_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .byte_in  (byte_in),
        .drain_ok (drain_ok),
        .step     (step),
        .byte_q   (byte_q)
    );

    // The parse stage advances its phase and counters once per byte moved on,
    // producing at most one result for it.
    rcap_parse_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .byte_q          (byte_q),
        .max_elements    (max_elements_reg),
        .max_bulk_length (max_bulk_length_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    rcap_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .drain_ok  (drain_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_q     (res_q)
    );

    assign event_kind      = res_q.kind;
    assign data_byte       = res_q.data;
    assign element_index   = res_q.index;
    assign element_length  = res_q.length;
    assign is_null         = res_q.is_null;
    assign last_of_command = res_q.last;
    assign error_code      = res_q.code;

endmodule

// ----- design/rcap_checker.sv -----
// Port-level checks for the RESP array request parser, and the bind that attaches
// them to resp_command_array_parser. Uses rcap_pkg.
module rcap_checker
    import rcap_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  event_kind,
    input logic [7:0]  data_byte,
    input logic [15:0] element_index,
    input logic [31:0] element_length,
    input logic        is_null,
    input logic        last_of_command,
    input logic [2:0]  error_code
);

    // A stalled result keeps its kind, data, index, length and error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
        $stable(data_byte) && $stable(element_index) && $stable(element_length) &&
        $stable(error_code))
    else $error("rcap: stalled result changed");

    // An error event carries a code, with zero index and length and no null or last mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_ERR |-> error_code != ERR_NONE &&
        element_index == 16'd0 && element_length == 32'd0 && !is_null &&
        !last_of_command)
    else $error("rcap: malformed error event");

    // Only error events carry an error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_ERR |-> error_code == ERR_NONE)
    else $error("rcap: error code on a non-error event");

    // Null and last marks appear only on element-complete events; null means length zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (is_null || last_of_command) |-> event_kind == EV_ELEM &&
        (!is_null || element_length == 32'd0))
    else $error("rcap: null or last mark on wrong event");

endmodule

bind resp_command_array_parser rcap_checker u_rcap_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_kind      (event_kind),
    .data_byte       (data_byte),
    .element_index   (element_index),
    .element_length  (element_length),
    .is_null         (is_null),
    .last_of_command (last_of_command),
    .error_code      (error_code)
);

// ----- bench/resp_command_array_parser_tb.sv -----
// Self-checking testbench for resp_command_array_parser.
// A behavioral parser inside the bench predicts every event from the accepted request
// bytes; it depends only on rcap_pkg and the RTL of the parser.
module resp_command_array_parser_tb
    import rcap_pkg::*;
;

    // Two carriage-return / line-feed bytes, used to build directed requests.
    localparam string CRLF = "\015\012";

    // Largest value a bulk length may take at the default length width.
    localparam logic [63:0] LEN_CAP = (LENGTH_BITS_DEF >= 64) ? '1 :
                                      (64'd1 << LENGTH_BITS_DEF) - 64'd1;

    // Cycles with no item moving on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 2000;

    // Cycles allowed for an item without an event to leave the parser pipeline.
    localparam int PIPE_DRAIN = 5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_kind;
    logic [7:0]  data_byte;
    logic [15:0] element_index;
    logic [31:0] element_length;
    logic        is_null;
    logic        last_of_command;
    logic [2:0]  error_code;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = 1'b0;
    logic [31:0] cfg_data = 32'h0;

    resp_command_array_parser dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .byte_in         (byte_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .event_kind      (event_kind),
        .data_byte       (data_byte),
        .element_index   (element_index),
        .element_length  (element_length),
        .is_null         (is_null),
        .last_of_command (last_of_command),
        .error_code      (error_code),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Events predicted for accepted bytes, oldest first.
    res_t pending_events[$];
    int   mismatch_count = 0;
    int   quiet_cycles = 0;

    // Percent chance, per cycle, that the sender idles or the receiver stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Bench copy of the two limit registers.
    logic [15:0] lim_elements = MAX_ELEMENTS_RST;
    logic [31:0] lim_bulk = MAX_BULK_LENGTH_RST;

    // Bench copy of the parser state.
    phase_t      parse_st = PH_IDLE;
    logic [63:0] num_acc = '0;
    bit          got_digit = 1'b0;
    logic [15:0] elems_left = '0;
    logic [15:0] elem_idx = '0;
    logic [63:0] data_left = '0;
    logic [63:0] data_len = '0;

    // Request under construction in the random part.
    logic [7:0] req_bytes[$];

    //------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------

    function automatic void clear_command();
        parse_st   = PH_IDLE;
        num_acc    = '0;
        got_digit  = 1'b0;
        elems_left = '0;
        elem_idx   = '0;
        data_left  = '0;
        data_len   = '0;
    endfunction

    // Any protocol error drops the command under way and returns to waiting for '*'.
    function automatic bit reject(input err_t code, output res_t ev);
        clear_command();
        ev      = '0;
        ev.kind = EV_ERR;
        ev.code = code;
        return 1'b1;
    endfunction

    // Returns 0 when the new digit pushes the number past the limit.
    function automatic bit take_digit(input logic [7:0] b, input logic [63:0] limit);
        num_acc   = num_acc * 64'd10 + 64'(b - CH_ZERO);
        got_digit = 1'b1;
        return num_acc <= limit;
    endfunction

    function automatic bit close_element(input bit nul, output res_t ev);
        ev         = '0;
        ev.kind    = EV_ELEM;
        ev.index   = elem_idx;
        ev.length  = nul ? 32'd0 : data_len[31:0];
        ev.is_null = nul;
        ev.last    = (elems_left == 16'd1);
        elem_idx   = elem_idx + 16'd1;
        elems_left = elems_left - 16'd1;
        data_left  = '0;
        data_len   = '0;
        if (elems_left == 16'd0)
            clear_command();
        else
            parse_st = PH_DOLLAR;
        return 1'b1;
    endfunction

    // Advances the bench parser by one byte; returns 1 when the byte yields an event.
    function automatic bit predict_event(input logic [7:0] b, output res_t ev);
        bit          digit;
        bit          hit;
        logic [63:0] limit;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        hit   = 1'b0;
        ev    = '0;
        case (parse_st)
            PH_IDLE:
            begin
                if (b != CH_STAR)
                    hit = reject(ERR_BYTE, ev);
                else
                begin
                    parse_st  = PH_COUNT;
                    num_acc   = '0;
                    got_digit = 1'b0;
                end
            end
            PH_COUNT:
            begin
                limit = (lim_elements < COUNT_CAP) ? 64'(lim_elements) : 64'(COUNT_CAP);
                if (digit)
                begin
                    if (!take_digit(b, limit))
                        hit = reject(ERR_COUNT, ev);
                end
                else if (b == CH_CR && got_digit)
                    parse_st = PH_COUNT_LF;
                else
                    hit = reject(ERR_BYTE, ev);
            end
            PH_COUNT_LF:
            begin
                if (b != CH_LF)
                    hit = reject(ERR_BYTE, ev);
                else if (num_acc == 64'd0)
                    hit = reject(ERR_EMPTY, ev);
                else
                begin
                    elems_left = num_acc[15:0];
                    elem_idx   = '0;
                    parse_st   = PH_DOLLAR;
                end
            end
            PH_DOLLAR:
            begin
                if (b != CH_DOLLAR)
                    hit = reject(ERR_BYTE, ev);
                else
                begin
                    parse_st  = PH_LEN;
                    num_acc   = '0;
                    got_digit = 1'b0;
                end
            end
            PH_LEN:
            begin
                limit = (64'(lim_bulk) < LEN_CAP) ? 64'(lim_bulk) : LEN_CAP;
                if (digit)
                begin
                    if (!take_digit(b, limit))
                        hit = reject(ERR_LEN, ev);
                end
                else if (b == CH_MINUS && !got_digit)
                    parse_st = PH_NULL_ONE;
                else if (b == CH_CR && got_digit)
                    parse_st = PH_LEN_LF;
                else
                    hit = reject(ERR_BYTE, ev);
            end
            PH_NULL_ONE:
            begin
                if (b != CH_ONE)
                    hit = reject(ERR_BYTE, ev);
                else
                    parse_st = PH_NULL_CR;
            end
            PH_NULL_CR:
            begin
                if (b != CH_CR)
                    hit = reject(ERR_BYTE, ev);
                else
                    parse_st = PH_NULL_LF;
            end
            PH_NULL_LF:
            begin
                if (b != CH_LF)
                    hit = reject(ERR_BYTE, ev);
                else
                    hit = close_element(1'b1, ev);
            end
            PH_LEN_LF:
            begin
                if (b != CH_LF)
                    hit = reject(ERR_BYTE, ev);
                else
                begin
                    data_len  = num_acc & LEN_CAP;
                    data_left = data_len;
                    parse_st  = (data_left == 64'd0) ? PH_DATA_CR : PH_DATA;
                end
            end
            PH_DATA:
            begin
                // Payload bytes are passed through unchecked, CR and LF included.
                ev.kind   = EV_BYTE;
                ev.data   = b;
                ev.index  = elem_idx;
                ev.length = data_len[31:0];
                hit       = 1'b1;
                if (data_left > 64'd0)
                    data_left = data_left - 64'd1;
                if (data_left == 64'd0)
                    parse_st = PH_DATA_CR;
            end
            PH_DATA_CR:
            begin
                if (b != CH_CR)
                    hit = reject(ERR_BYTE, ev);
                else
                    parse_st = PH_DATA_LF;
            end
            PH_DATA_LF:
            begin
                if (b != CH_LF)
                    hit = reject(ERR_BYTE, ev);
                else
                    hit = close_element(1'b0, ev);
            end
            default:
                hit = reject(ERR_BYTE, ev);
        endcase
        return hit;
    endfunction

    //------------------------------------------------------------------------
    // Monitors
    //------------------------------------------------------------------------

    // Both channels are sampled at the rising edge. The output side is checked first;
    // an item accepted at this edge cannot have its event shown at the same edge anyway.
    always @(posedge clk)
    begin
        res_t want;
        res_t ev;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected event: kind %0d data %h idx %0d len %0d err %0d",
                                 event_kind, data_byte, element_index, element_length,
                                 error_code);
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind || data_byte !== want.data ||
                        element_index !== want.index || element_length !== want.length ||
                        is_null !== want.is_null || last_of_command !== want.last ||
                        error_code !== want.code)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("event mismatch at %0t", $realtime);
                            $display("  expected kind %0d data %h idx %0d len %0d",
                                     want.kind, want.data, want.index, want.length);
                            $display("           null %b last %b err %0d",
                                     want.is_null, want.last, want.code);
                            $display("  actual   kind %0d data %h idx %0d len %0d",
                                     event_kind, data_byte, element_index, element_length);
                            $display("           null %b last %b err %0d",
                                     is_null, last_of_command, error_code);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (predict_event(byte_in, ev))
                    pending_events.insert(pending_events.size(), ev);
            end
        end
    end

    // The receiver stalls at random with the chance set by the running test.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: gives up when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    //------------------------------------------------------------------------
    // Drivers
    //------------------------------------------------------------------------

    // Offers one byte, idling first at random, and returns at the edge that takes it.
    // Valid is only lowered in an idle cycle, so back-to-back items keep it high.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Stops sending, waits for every predicted event, then lets the pipeline empty.
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // Register writes happen only with the parser drained, so the bench copy can be
    // updated right away without racing an item in flight.
    task automatic write_reg(input cfg_reg_t which, input logic [31:0] value);
        wait_quiet();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (which == REG_MAX_ELEMENTS)
            lim_elements = value[15:0];
        else
            lim_bulk = value;
    endtask

    //------------------------------------------------------------------------
    // Request builder for the random part
    //------------------------------------------------------------------------

    // Appends one byte to the request under construction.
    function automatic void add_byte(input logic [7:0] b);
        req_bytes.insert(req_bytes.size(), b);
    endfunction

    function automatic void push_decimal(input logic [63:0] value, input int zeros);
        logic [7:0] digits[$];
        repeat (zeros) add_byte(CH_ZERO);
        do
        begin
            digits.push_front(CH_ZERO + 8'(value % 64'd10));
            value = value / 64'd10;
        end
        while (value != 64'd0);
        foreach (digits[i])
            add_byte(digits[i]);
    endfunction

    function automatic int pad_zeros();
        return ($urandom_range(99) < 10) ? int'($urandom_range(1, 2)) : 0;
    endfunction

    function automatic void push_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    // Builds one request, mostly well formed with random payload. Counts and lengths
    // sit on or just past the limit when it is small enough to reach; some requests are
    // empty, some carry stray bytes ahead of them, and some get one byte damaged.
    function automatic void build_request();
        int count;
        int len;
        int pos;
        logic [7:0] junk;
        req_bytes.delete();
        if ($urandom_range(99) < 5)
            repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range(255)));
        if (lim_elements <= 16'd8 && $urandom_range(99) < 15)
            count = int'(lim_elements) + int'($urandom_range(0, 1));
        else if ($urandom_range(99) < 3)
            count = 0;
        else
            count = $urandom_range(1, 4);
        add_byte(CH_STAR);
        push_decimal(64'(count), pad_zeros());
        push_crlf();
        for (int e = 0; e < count; e++)
        begin
            add_byte(CH_DOLLAR);
            if ($urandom_range(99) < 10)
            begin
                add_byte(CH_MINUS);
                add_byte(CH_ONE);
                push_crlf();
            end
            else
            begin
                if (lim_bulk <= 32'd16 && $urandom_range(99) < 20)
                    len = int'(lim_bulk) + int'($urandom_range(0, 1));
                else
                    len = $urandom_range(0, 8);
                push_decimal(64'(len), pad_zeros());
                push_crlf();
                repeat (len) add_byte(8'($urandom_range(255)));
                push_crlf();
            end
        end
        // Damage keeps digits out so a broken length can never grow large.
        if ($urandom_range(99) < 12)
        begin
            pos = $urandom_range(0, req_bytes.size() - 1);
            if ($urandom_range(1))
                req_bytes.delete(pos);
            else
            begin
                junk = 8'($urandom_range(255));
                if (junk >= CH_ZERO && junk <= CH_NINE)
                    junk = junk ^ 8'h40;
                req_bytes[pos] = junk;
            end
        end
    endfunction

    //------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------

    // Stray bytes at both extremes, then one command with a null element, an empty
    // element and a payload byte that is itself a CR, ending with the last mark.
    task automatic test_well_formed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text({"*3", CRLF, "$-1", CRLF, "$0", CRLF, CRLF, "$1", CRLF, "\015", CRLF});
    endtask

    // Empty array, a byte out of place after the count (it must not restart a
    // command), a '-' that follows digits, and a count with no digits.
    task automatic test_protocol_errors();
        send_text({"*0", CRLF});
        send_text("*1\015*");
        send_text({"*1", CRLF, "$1-"});
        send_text("*\015");
    endtask

    // Limits at the top of their range and near or at the bottom, with leading zeros under a zero limit.
    task automatic test_limit_extremes();
        write_reg(REG_MAX_ELEMENTS, 32'd1);
        write_reg(REG_MAX_BULK_LENGTH, 32'd0);
        send_text("*2");
        send_text({"*1", CRLF, "$00", CRLF, CRLF});
        send_text({"*1", CRLF, "$1"});
        write_reg(REG_MAX_ELEMENTS, 32'hFFFF);
        write_reg(REG_MAX_BULK_LENGTH, 32'hFFFF_FFFF);
        send_text("*65536");
        send_text({"*1", CRLF, "$4294967296"});
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [15:0] elements,
                                       input logic [31:0] bulk, input int n_items);
        int sent;
        write_reg(REG_MAX_ELEMENTS, 32'(elements));
        write_reg(REG_MAX_BULK_LENGTH, bulk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            build_request();
            foreach (req_bytes[i])
                send_byte(req_bytes[i]);
            sent += req_bytes.size();
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_well_formed();
        test_protocol_errors();
        test_limit_extremes();
        test_random_traffic(0, 0, MAX_ELEMENTS_RST, MAX_BULK_LENGTH_RST, 350);
        test_random_traffic(48, 0, 16'd3, 32'd5, 350);
        test_random_traffic(0, 48, 16'd1, 32'd0, 300);
        test_random_traffic(36, 36, 16'hFFFF, 32'hFFFF_FFFF, 400);

        wait_quiet();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
